// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/jsu_pkg.sv
package jsu_pkg;

  // Parser modes
  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_TEXT     = 3'd1,
    MODE_ESC      = 3'd2,
    MODE_HEX      = 3'd3,
    MODE_HELD     = 3'd4,
    MODE_HELD_ESC = 3'd5
  } mode_t;

  // Characters with a meaning to the parser
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  // Control bytes produced by short escapes
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam int          MAX_BYTES    = 4;

  // Bytes caused by one input item
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } emit_t;

  // One queued group: the results of one input item
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            str_end;
    logic            unterm;
  } grp_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Encode a code point as UTF-8; zero gives no bytes
  function automatic emit_t jsu_encode(input logic [20:0] cp);
    emit_t e;
    e = '0;
    if (cp == 21'd0) begin
      e.cnt = 3'd0;
    end else if (cp < 21'h80) begin
      e.bytes[0] = cp[7:0];
      e.cnt      = 3'd1;
    end else if (cp < 21'h800) begin
      e.bytes[0] = 8'hC0 | {3'd0, cp[10:6]};
      e.bytes[1] = 8'h80 | {2'd0, cp[5:0]};
      e.cnt      = 3'd2;
    end else if (cp < 21'h10000) begin
      e.bytes[0] = 8'hE0 | {4'd0, cp[15:12]};
      e.bytes[1] = 8'h80 | {2'd0, cp[11:6]};
      e.bytes[2] = 8'h80 | {2'd0, cp[5:0]};
      e.cnt      = 3'd3;
    end else begin
      e.bytes[0] = 8'hF0 | {5'd0, cp[20:18]};
      e.bytes[1] = 8'h80 | {2'd0, cp[17:12]};
      e.bytes[2] = 8'h80 | {2'd0, cp[11:6]};
      e.bytes[3] = 8'h80 | {2'd0, cp[5:0]};
      e.cnt      = 3'd4;
    end
    return e;
  endfunction

  // Decode one hex digit
  function automatic hex_t jsu_hex(input logic [7:0] b);
    hex_t h;
    h = '0;
    if (b inside {[8'h30:8'h39]}) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h30);
    end else if (b inside {[8'h61:8'h66]}) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h57);
    end else if (b inside {[8'h41:8'h46]}) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h37);
    end
    return h;
  endfunction

  // Map the byte after a backslash to its output byte
  function automatic logic [7:0] jsu_esc_map(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      CH_B:    r = CTL_BS;
      CH_F:    r = CTL_FF;
      CH_N:    r = CTL_LF;
      CH_R:    r = CTL_CR;
      CH_T:    r = CTL_HT;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/jsu_front.sv
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_first,
  input  logic       q_full,
  output logic       q_push,
  output grp_t       q_data
);

  mode_t       mode_r, mode_nxt;
  logic [2:0]  digits_r, digits_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        stopped_r, stopped_nxt;
  logic [15:0] held_r, held_nxt;
  logic        low_r, low_nxt;

  logic        accept;
  logic        is_nul, is_quote, is_bs, is_u;
  logic        text_act, esc_act, emit_held, hex_mode;
  logic        hex_start, hex_done, hold_new;
  hex_t        hx;
  logic [2:0]  digits_inc;
  logic [15:0] acc_step, acc_fin;
  logic        stopped_step;
  logic [20:0] cp_low, cp_sel;
  logic        emit_en, push_en, end_en, unterm_en;
  logic [7:0]  push_byte;
  emit_t       enc;
  grp_t        grp;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the incoming byte
  assign is_nul   = (in_byte == CH_NUL);
  assign is_quote = (in_byte == CH_QUOTE);
  assign is_bs    = (in_byte == CH_BSLASH);
  assign is_u     = (in_byte == CH_U);
  assign hx       = jsu_hex(in_byte);

  // Decide which handler the byte goes to
  assign emit_held = ((mode_r == MODE_HELD) && !is_bs) || ((mode_r == MODE_HELD_ESC) && !is_u);
  assign text_act  = (mode_r == MODE_TEXT) || ((mode_r == MODE_HELD) && !is_bs);
  assign esc_act   = (mode_r == MODE_ESC) || ((mode_r == MODE_HELD_ESC) && !is_u);
  assign hex_mode  = (mode_r == MODE_HEX);
  assign hex_start = (esc_act && is_u) || ((mode_r == MODE_HELD_ESC) && is_u);

  // Step the hex run
  assign digits_inc   = 3'(digits_r + 3'd1);
  assign acc_step     = (!stopped_r && hx.ok) ? {acc_r[11:0], hx.val} : acc_r;
  assign stopped_step = stopped_r || !hx.ok;
  assign acc_fin      = is_nul ? acc_r : acc_step;
  assign hex_done     = hex_mode && (is_nul || (digits_inc >= 3'd4));
  assign hold_new     = hex_done && !is_nul && !low_r &&
                        (acc_fin >= SURR_HI_BASE) && (acc_fin < SURR_LO_BASE);

  // Combine a surrogate pair; the held half always lies in the high range
  assign cp_low = SUPP_BASE + {1'b0, held_r[9:0], 10'd0} + {5'd0, acc_fin} - {5'd0, SURR_LO_BASE};

  // Next parser mode
  always_comb begin
    mode_nxt = mode_r;
    if (in_first) begin
      mode_nxt = MODE_TEXT;
    end else begin
      case (mode_r)
        MODE_TEXT, MODE_HELD: begin
          if ((mode_r == MODE_HELD) && is_bs) mode_nxt = MODE_HELD_ESC;
          else if (is_nul || is_quote)        mode_nxt = MODE_IDLE;
          else if (is_bs)                     mode_nxt = MODE_ESC;
          else                                mode_nxt = MODE_TEXT;
        end
        MODE_ESC, MODE_HELD_ESC: begin
          if (is_u)        mode_nxt = MODE_HEX;
          else if (is_nul) mode_nxt = MODE_IDLE;
          else             mode_nxt = MODE_TEXT;
        end
        MODE_HEX: begin
          if (is_nul)              mode_nxt = MODE_IDLE;
          else if (hold_new)       mode_nxt = MODE_HELD;
          else if (hex_done)       mode_nxt = MODE_TEXT;
          else                     mode_nxt = MODE_HEX;
        end
        default: mode_nxt = MODE_IDLE;
      endcase
    end
  end

  // Select the code point and the single byte to emit
  always_comb begin
    emit_en   = 1'b0;
    cp_sel    = 21'd0;
    push_en   = 1'b0;
    push_byte = in_byte;
    end_en    = 1'b0;
    unterm_en = 1'b0;
    if (emit_held) begin
      emit_en = 1'b1;
      cp_sel  = {5'd0, held_r};
    end else if (hex_done && low_r) begin
      emit_en = 1'b1;
      cp_sel  = cp_low;
    end else if (hex_done && !hold_new) begin
      emit_en = 1'b1;
      cp_sel  = {5'd0, acc_fin};
    end
    if (text_act) begin
      if (is_nul || is_quote) begin
        end_en    = 1'b1;
        unterm_en = is_nul;
      end else if (!is_bs) begin
        push_en = 1'b1;
      end
    end else if (esc_act) begin
      if (is_nul) begin
        end_en    = 1'b1;
        unterm_en = 1'b1;
      end else if (!is_u) begin
        push_en   = 1'b1;
        push_byte = jsu_esc_map(in_byte);
      end
    end else if (hex_mode && is_nul) begin
      end_en    = 1'b1;
      unterm_en = 1'b1;
    end
  end

  // Build the result group
  always_comb begin
    enc         = jsu_encode(emit_en ? cp_sel : 21'd0);
    grp.bytes   = enc.bytes;
    grp.cnt     = enc.cnt;
    grp.str_end = end_en;
    grp.unterm  = unterm_en;
    if (push_en) begin
      grp.bytes[enc.cnt[1:0]] = push_byte;
      grp.cnt                 = 3'(enc.cnt + 3'd1);
    end
  end

  assign q_push = accept && !in_first && ((grp.cnt != 3'd0) || grp.str_end);
  assign q_data = grp;

  // Next hex and surrogate state
  always_comb begin
    digits_nxt  = digits_r;
    acc_nxt     = acc_r;
    stopped_nxt = stopped_r;
    held_nxt    = held_r;
    low_nxt     = low_r;
    if (in_first) begin
      digits_nxt  = 3'd0;
      acc_nxt     = 16'd0;
      stopped_nxt = 1'b0;
      held_nxt    = 16'd0;
      low_nxt     = 1'b0;
    end else if (hex_start) begin
      digits_nxt  = 3'd0;
      acc_nxt     = 16'd0;
      stopped_nxt = 1'b0;
      low_nxt     = (mode_r == MODE_HELD_ESC);
    end else if (hex_mode) begin
      if (!is_nul) begin
        digits_nxt  = digits_inc;
        acc_nxt     = acc_step;
        stopped_nxt = stopped_step;
      end
      if (hex_done) low_nxt = 1'b0;
      if (hold_new) held_nxt = acc_fin;
    end
  end

  // Update state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      digits_r  <= 3'd0;
      acc_r     <= 16'd0;
      stopped_r <= 1'b0;
      held_r    <= 16'd0;
      low_r     <= 1'b0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      digits_r  <= digits_nxt;
      acc_r     <= acc_nxt;
      stopped_r <= stopped_nxt;
      held_r    <= held_nxt;
      low_r     <= low_nxt;
    end
  end

endmodule

// File: hdl/jsu_queue.sv
`include "assert_macros.svh"

module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_data,
  input  logic pop,
  output grp_t pop_data,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  grp_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty    = (count_r == CNT_W'(0));
  assign full     = (count_r == CNT_W'(DEPTH));
  assign pop_data = mem_r[rd_ptr_r];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    if (push && !pop)      count_nxt = CNT_W'(count_r + 1'b1);
    else if (pop && !push) count_nxt = CNT_W'(count_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  `JSU_ASSERT(a_no_overflow, push |-> (!full || pop), "queue push while full")
  `JSU_ASSERT(a_no_underflow, pop |-> !empty, "queue pop while empty")
  `JSU_ASSERT(a_count_tracks, (push && !pop) |=> (count_r == CNT_W'($past(count_r) + 1'b1)), "queue count lost a push")

endmodule

// File: hdl/jsu_back.sv
`include "assert_macros.svh"

module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  grp_t       q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_string_end,
  output logic       out_unterminated,
  output logic       out_last
);

  grp_t       cur_r, cur_nxt;
  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       has_data;

  // Present the current byte of the group
  assign has_data         = (cur_r.cnt != 3'd0);
  assign out_valid        = valid_r;
  assign out_byte_valid   = has_data;
  assign out_byte         = has_data ? cur_r.bytes[idx_r] : 8'd0;
  assign out_last         = !has_data || ({1'b0, idx_r} == 3'(cur_r.cnt - 3'd1));
  assign out_string_end   = out_last && cur_r.str_end;
  assign out_unterminated = out_last && cur_r.str_end && cur_r.unterm;

  // Load the next group once the current one is drained
  assign q_pop = !q_empty && (!valid_r || (out_ready && out_last));

  always_comb begin
    cur_nxt   = cur_r;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (q_pop) begin
      cur_nxt   = q_data;
      valid_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (valid_r && out_ready) begin
      if (out_last) valid_nxt = 1'b0;
      else          idx_nxt   = 2'(idx_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Hold the group payload
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  `JSU_ASSERT(a_idx_in_group, (valid_r && has_data) |-> ({1'b0, idx_r} < cur_r.cnt), "byte index past group end")
  `JSU_ASSERT(a_idx_steps, (valid_r && out_ready && !out_last) |=> (idx_r == 2'($past(idx_r) + 2'd1)), "byte index did not advance")
  `JSU_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !valid_r, "output valid after reset")

endmodule

// File: hdl/json_string_unescape_utf8.sv
// When idle, the first result passes through the queue and then the output register.
// Throughput: one input byte per cycle while each byte yields at most one result and
// out_ready stays high; in_ready falls while the queue is full. An item with several
// results holds the output serializer until all are taken, and a queue of QUEUE_DEPTH
// result groups lets the parser run ahead of the serializer meanwhile.
// Reset: synchronous, active low; clears the parser state, the queue and the output.
module json_string_unescape_utf8
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_first,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_string_end,
  output logic       out_unterminated,
  output logic       out_last
);

  logic q_push, q_pop, q_empty, q_full;
  grp_t q_wdata, q_rdata;

  // Parse and classify input bytes
  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_first (in_first),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // Buffer result groups
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Serialize groups into result transactions
  jsu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_string_end   (out_string_end),
    .out_unterminated (out_unterminated),
    .out_last         (out_last)
  );

endmodule
